/* hw/rtl/ffa_pkg.sv */
package ffa_pkg;

  // arena geometry
  localparam int ARENA_GRANULES = 4096;
  localparam int GRAN_BYTES     = 16;
  localparam int GRAN_SH        = $clog2(GRAN_BYTES);
  localparam int IDX_W          = $clog2(ARENA_GRANULES);
  localparam int LINK_W         = IDX_W + 1;
  localparam int HDR_W          = LINK_W + 1;
  localparam int ADDR_W         = 16;
  localparam int CFG_W          = 17;
  localparam logic [CFG_W-1:0] MIN_GROW_RESET = 17'd4112;

  // request kinds
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] request_bytes;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] user_address;
    logic              ok;
    logic [ADDR_W-1:0] usable_bytes;
  } res_t;

endpackage

/* hw/rtl/ffa_ram.sv */
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/ffa_engine.sv */
module ffa_engine import ffa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] min_grow_bytes,
  input  logic             start,
  input  req_t             req,
  output logic             idle,
  output res_t             res,
  output logic             res_valid,
  input  logic             res_ready
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_TAIL  = 7'b0010000,
    S_GROW  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  localparam logic [LINK_W:0] ARENA_END = (LINK_W+1)'(ARENA_GRANULES);

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_r, clr_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [LINK_W-1:0]   need_r, need_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [LINK_W-1:0]   m_r, m_nxt;
  logic [LINK_W-1:0]   heap_end_r, heap_end_nxt;
  logic [LINK_W:0]     grow_r, grow_nxt;
  logic                grow_need_r, grow_need_nxt;
  res_t                res_r, res_nxt;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [HDR_W-1:0]    ram_wdata, ram_rdata;

  logic [LINK_W-1:0]   d_link;
  logic                d_taken;
  logic [IDX_W-1:0]    gran_idx;
  logic                hdr_valid;
  logic [IDX_W-1:0]    hdr_idx;
  logic [CFG_W:0]      mg_sum;
  logic [LINK_W:0]     mg;
  logic [LINK_W:0]     he_sum;
  logic [LINK_W:0]     place_end;
  logic [CFG_W-1:0]    end_bytes;
  logic [CFG_W-1:0]    addr_ext;
  logic [ADDR_W-1:0]   grant_addr;

  ffa_ram #(
    .WIDTH (HDR_W),
    .DEPTH (ARENA_GRANULES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // header fields and address decode
  assign d_link     = ram_rdata[HDR_W-1:1];
  assign d_taken    = ram_rdata[0];
  assign gran_idx   = addr_r[ADDR_W-1:GRAN_SH];
  assign hdr_valid  = (gran_idx != '0);
  assign hdr_idx    = gran_idx - IDX_W'(1);
  assign mg_sum     = {1'b0, min_grow_bytes} + (CFG_W+1)'(GRAN_BYTES - 1);
  assign mg         = (LINK_W+1)'(mg_sum >> GRAN_SH);
  assign he_sum     = {1'b0, heap_end_r} + grow_r;
  assign place_end  = {1'b0, m_r} + {1'b0, need_r};
  assign end_bytes  = {d_link, {GRAN_SH{1'b0}}};
  assign addr_ext   = {1'b0, addr_r};
  assign grant_addr = {m_r[IDX_W-1:0] + IDX_W'(1), {GRAN_SH{1'b0}}};

  // control and header walk
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    kind_nxt      = kind_r;
    need_nxt      = need_r;
    addr_nxt      = addr_r;
    m_nxt         = m_r;
    heap_end_nxt  = heap_end_r;
    grow_nxt      = grow_r;
    grow_need_nxt = grow_need_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = m_r[IDX_W-1:0];
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = m_r[IDX_W-1:0];
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + IDX_W'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          kind_nxt  = req.kind;
          need_nxt  = LINK_W'(req.request_bytes >> GRAN_SH) + LINK_W'(2);
          addr_nxt  = req.block_address;
          m_nxt     = '0;
          res_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = (kind_r == KIND_ALLOC) ? m_r[IDX_W-1:0] : hdr_idx;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        case (kind_r)
          KIND_ALLOC: begin
            if (d_link == '0) begin
              state_nxt = S_TAIL;
            end else if (!d_taken && d_link > m_r && (d_link - m_r) >= need_r) begin
              // first fit: take the block and keep its length
              ram_we               = 1'b1;
              ram_wdata            = {d_link, 1'b1};
              res_nxt.user_address = grant_addr;
              res_nxt.ok           = 1'b1;
              state_nxt            = S_DONE;
            end else if (d_link <= m_r) begin
              state_nxt = S_TAIL;
            end else begin
              m_nxt = d_link;
              if (d_link == heap_end_r || d_link[LINK_W-1]) begin
                state_nxt = S_TAIL;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = d_link[IDX_W-1:0];
              end
            end
          end
          KIND_FREE: begin
            ram_waddr  = hdr_idx;
            ram_wdata  = {d_link, 1'b0};
            ram_we     = hdr_valid;
            res_nxt.ok = 1'b1;
            state_nxt  = S_DONE;
          end
          KIND_QUERY: begin
            if (hdr_valid && d_link != '0) begin
              res_nxt.ok = 1'b1;
              if (end_bytes >= addr_ext) begin
                res_nxt.usable_bytes = ADDR_W'(end_bytes - addr_ext);
              end
            end
            state_nxt = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_TAIL: begin
        if (m_r[LINK_W-1]) begin
          state_nxt = S_DONE;
        end else begin
          grow_need_nxt = ({1'b0, heap_end_r} <= place_end);
          grow_nxt      = ({1'b0, need_r} > mg) ? {1'b0, need_r} : mg;
          state_nxt     = S_GROW;
        end
      end
      S_GROW: begin
        state_nxt = S_DONE;
        if (!(grow_need_r && he_sum > ARENA_END)) begin
          if (grow_need_r) begin
            heap_end_nxt = he_sum[LINK_W-1:0];
          end
          if (place_end <= ARENA_END) begin
            // new block at the tail
            ram_we               = 1'b1;
            ram_wdata            = {place_end[LINK_W-1:0], 1'b1};
            res_nxt.user_address = grant_addr;
            res_nxt.ok           = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      heap_end_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      heap_end_r <= heap_end_nxt;
    end
  end

  // transaction payload
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    need_r      <= need_nxt;
    addr_r      <= addr_nxt;
    m_r         <= m_nxt;
    grow_r      <= grow_nxt;
    grow_need_r <= grow_need_nxt;
    res_r       <= res_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // heap end never passes the arena
  a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, heap_end_r} <= ARENA_END)
    else $error("heap end beyond arena");

  // heap end moves only on the growth step
  a_heap_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_GROW) |=> $stable(heap_end_r))
    else $error("heap end changed outside growth step");

  // no read of an entry in the cycle it is written
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re && ram_waddr == ram_raddr))
    else $error("header read and write collide");

  // nothing starts during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !res_valid && !idle)
    else $error("activity during clearing pass");

endmodule

/* hw/rtl/first_fit_block_allocator_core.sv */
// First-fit allocator over a 64 KiB arena of 16-byte granules, headers kept in a
// 4096-entry on-chip memory. After reset a clearing pass writes every header, during which
// in_tready stays low (configuration writes are still taken). A free or query transaction
// reads its header, evaluates it and passes the result to the output register; an allocate
// reads one block header after another, as the walk does one header read per cycle on the
// memory's single read port, and goes through the tail and growth steps when the block is
// placed at the tail. One request is in work at a time; a new one is accepted while the
// previous result still waits on the output.
module first_fit_block_allocator_core import ffa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,   // request_bytes[15:0], block_address[31:16]
  input  logic [1:0]       in_tuser,   // kind[1:0]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // user_address[15:0], usable_bytes[31:16]
  output logic [0:0]       out_tuser,  // ok[0]
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  logic [CFG_W-1:0] min_grow_r;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r;
  req_t             req;
  res_t             eng_res;
  logic             eng_idle, eng_res_valid, eng_res_ready;

  // minimum growth register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_grow_r <= MIN_GROW_RESET;
    end else if (cfg_wr_en) begin
      min_grow_r <= cfg_wr_data;
    end
  end

  assign req.kind          = in_tuser;
  assign req.request_bytes = in_tdata[15:0];
  assign req.block_address = in_tdata[31:16];
  assign in_tready         = eng_idle;

  ffa_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .min_grow_bytes (min_grow_r),
    .start          (in_tvalid && in_tready),
    .req            (req),
    .idle           (eng_idle),
    .res            (eng_res),
    .res_valid      (eng_res_valid),
    .res_ready      (eng_res_ready)
  );

  // output register
  assign eng_res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (eng_res_ready) begin
      out_valid_nxt = eng_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_ready && eng_res_valid) begin
      out_res_r <= eng_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.usable_bytes, out_res_r.user_address};
  assign out_tuser  = out_res_r.ok;

endmodule
